>>> rtl/core/qbs_pkg.sv
// shared constants and width helpers for the quadratic bezier sampler
package qbs_pkg;

    // default configuration
    localparam int SAMPLE_STEPS_DEF = 50;
    localparam int COORD_BITS_DEF   = 16;

    // result format
    localparam int OUT_BITS   = 24;
    localparam int IDX_BITS   = 6;
    localparam int FRAC_BITS  = 8;
    localparam int HALF_PIXEL = 128;

    // cycles from divider load until quotient and remainder are valid
    localparam int DIV_LAT = 2;

    // width of the scaled difference terms and of all quotients
    function automatic int num_bits(input int coord_bits);
        return coord_bits + 17;
    endfunction

    // width of a remainder against the divisor steps squared
    function automatic int rem_bits(input int steps);
        return $clog2(steps * steps + 1);
    endfunction

endpackage

>>> rtl/core/qbs_div.sv
// divider by the constant steps squared: reciprocal multiply and one correction, floor rounding
module qbs_div #(
    parameter int SAMPLE_STEPS = qbs_pkg::SAMPLE_STEPS_DEF,
    parameter int COORD_BITS   = qbs_pkg::COORD_BITS_DEF
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_load,
    input  logic signed [qbs_pkg::num_bits(COORD_BITS)-1:0] i_num,
    output logic        [qbs_pkg::num_bits(COORD_BITS)-1:0] o_quot,
    output logic        [qbs_pkg::rem_bits(SAMPLE_STEPS)-1:0] o_rem
);

    localparam int W  = qbs_pkg::num_bits(COORD_BITS);
    localparam int DW = qbs_pkg::rem_bits(SAMPLE_STEPS);
    localparam int D  = SAMPLE_STEPS * SAMPLE_STEPS;
    // dividend magnitudes stay below bit W-1
    localparam int MW = W - 1;
    // shift of the reciprocal: MW plus floor(log2 D), keeps the estimate at most one low
    localparam int SH = MW + DW - 1;
    localparam longint RECIP = (longint'(1) << SH) / longint'(D);
    localparam logic [MW:0] M = (MW+1)'(RECIP);

    logic [MW-1:0] r_mag;
    logic          r_neg;
    logic [W-1:0]  r_q0;
    logic [W-1:0]  r_q1;
    logic [DW:0]   r_r0;

    logic [W-1:0]    n_mag;
    logic [2*MW:0]   n_prod;
    logic [W-1:0]    n_q0;
    logic [W-1:0]    n_back;
    logic [DW:0]     n_r0;
    logic            n_fix;
    logic [W-1:0]    n_uq;
    logic [DW-1:0]   n_ur;

    // magnitude of the dividend
    assign n_mag = i_num[W-1] ? W'(-i_num) : W'(i_num);

    // quotient estimate and the remainder it leaves, in [0, 2D)
    always_comb begin
        n_prod = (2*MW+1)'(r_mag) * (2*MW+1)'(M);
        n_q0   = W'(n_prod >> SH);
        n_back = r_q0 * W'(D);
        n_r0   = (DW+1)'(W'(r_mag) - n_back);
    end

    // load stage, estimate stage, remainder stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_neg <= 1'b0;
        end else if (i_load) begin
            r_neg <= i_num[W-1];
        end
        if (i_load) begin
            r_mag <= n_mag[MW-1:0];
        end
        r_q0 <= n_q0;
        r_q1 <= r_q0;
        r_r0 <= n_r0;
    end

    // correct a low estimate, then turn it into floor quotient and positive remainder
    always_comb begin
        n_fix = (r_r0 >= (DW+1)'(D));
        n_uq  = r_q1 + W'(n_fix);
        n_ur  = n_fix ? DW'(r_r0 - (DW+1)'(D)) : r_r0[DW-1:0];
        if (r_neg && (n_ur != '0)) begin
            o_quot = ~n_uq;
            o_rem  = DW'(D) - n_ur;
        end else if (r_neg) begin
            o_quot = W'(-n_uq);
            o_rem  = '0;
        end else begin
            o_quot = n_uq;
            o_rem  = n_ur;
        end
    end

endmodule

>>> rtl/core/qbs_front.sv
// front end: takes control points and works out the difference terms
module qbs_front #(
    parameter int SAMPLE_STEPS = qbs_pkg::SAMPLE_STEPS_DEF,
    parameter int COORD_BITS   = qbs_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_ctrl_x,
    input  logic signed [COORD_BITS-1:0] i_ctrl_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    input  logic                         i_q_full,
    output logic                         o_q_wr,
    output logic [2*(COORD_BITS+2*qbs_pkg::num_bits(COORD_BITS)
                     +2*qbs_pkg::rem_bits(SAMPLE_STEPS))-1:0] o_q_data
);

    localparam int W  = qbs_pkg::num_bits(COORD_BITS);
    localparam int DW = qbs_pkg::rem_bits(SAMPLE_STEPS);
    localparam int CW = $clog2(qbs_pkg::DIV_LAT + 1);
    localparam logic signed [W-1:0] NS = W'(SAMPLE_STEPS);

    logic                         r_busy;
    logic [CW-1:0]                r_cnt;
    logic signed [COORD_BITS-1:0] r_p0x;
    logic signed [COORD_BITS-1:0] r_p0y;

    logic          n_accept;
    logic          n_done;
    logic          n_step;
    logic signed [W-1:0] n_ax, n_bx, n_ay, n_by;
    logic signed [W-1:0] n_d1x, n_d2x, n_d1y, n_d2y;
    logic [W-1:0]  q1x, q2x, q1y, q2y;
    logic [DW-1:0] r1x, r2x, r1y, r2y;

    // handshake and division sequencing
    assign n_done   = r_busy && (r_cnt == CW'(qbs_pkg::DIV_LAT));
    assign o_q_wr   = n_done && !i_q_full;
    assign full     = r_busy && !o_q_wr;
    assign n_accept = push && !full;
    assign n_step   = r_busy && (r_cnt != CW'(qbs_pkg::DIV_LAT));

    // second difference a = p0 - 2p1 + p2, first term b = 2(p1 - p0)
    always_comb begin
        n_ax  = W'(i_start_x) - (W'(i_ctrl_x) <<< 1) + W'(i_end_x);
        n_bx  = (W'(i_ctrl_x) - W'(i_start_x)) <<< 1;
        n_ay  = W'(i_start_y) - (W'(i_ctrl_y) <<< 1) + W'(i_end_y);
        n_by  = (W'(i_ctrl_y) - W'(i_start_y)) <<< 1;
        n_d1x = (NS * n_bx + n_ax) <<< qbs_pkg::FRAC_BITS;
        n_d2x = n_ax <<< (qbs_pkg::FRAC_BITS + 1);
        n_d1y = (NS * n_by + n_ay) <<< qbs_pkg::FRAC_BITS;
        n_d2y = n_ay <<< (qbs_pkg::FRAC_BITS + 1);
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (n_accept) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (o_q_wr) begin
            r_busy <= 1'b0;
        end else if (n_step) begin
            r_cnt <= r_cnt + CW'(1);
        end
    end

    // start point held for the record
    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_p0x <= i_start_x;
            r_p0y <= i_start_y;
        end
    end

    // four dividers run side by side
    qbs_div #(.SAMPLE_STEPS(SAMPLE_STEPS), .COORD_BITS(COORD_BITS)) u_div_d1x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_load(n_accept),
        .i_num(n_d1x), .o_quot(q1x), .o_rem(r1x)
    );
    qbs_div #(.SAMPLE_STEPS(SAMPLE_STEPS), .COORD_BITS(COORD_BITS)) u_div_d2x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_load(n_accept),
        .i_num(n_d2x), .o_quot(q2x), .o_rem(r2x)
    );
    qbs_div #(.SAMPLE_STEPS(SAMPLE_STEPS), .COORD_BITS(COORD_BITS)) u_div_d1y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_load(n_accept),
        .i_num(n_d1y), .o_quot(q1y), .o_rem(r1y)
    );
    qbs_div #(.SAMPLE_STEPS(SAMPLE_STEPS), .COORD_BITS(COORD_BITS)) u_div_d2y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_load(n_accept),
        .i_num(n_d2y), .o_quot(q2y), .o_rem(r2y)
    );

    // record for the back end
    assign o_q_data = {r_p0x, q1x, r1x, q2x, r2x, r_p0y, q1y, r1y, q2y, r2y};

endmodule

>>> rtl/core/qbs_fifo.sv
// two-entry queue between front and back end
module qbs_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_rd,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int DEPTH = 2;
    localparam int AW    = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp;
    logic [AW-1:0]    r_rp;
    logic [AW:0]      r_count;

    logic n_wr;
    logic n_rd;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign n_wr    = i_wr && !o_full;
    assign n_rd    = i_rd && !o_empty;
    assign o_data  = r_mem[r_rp];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (n_wr) begin
                r_wp <= r_wp + AW'(1);
            end
            if (n_rd) begin
                r_rp <= r_rp + AW'(1);
            end
            if (n_wr && !n_rd) begin
                r_count <= r_count + (AW+1)'(1);
            end else if (n_rd && !n_wr) begin
                r_count <= r_count - (AW+1)'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (n_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

>>> rtl/core/qbs_back.sv
// back end: forward differencing in quotient and remainder form, one sample a cycle while the output register is free
module qbs_back #(
    parameter int SAMPLE_STEPS = qbs_pkg::SAMPLE_STEPS_DEF,
    parameter int COORD_BITS   = qbs_pkg::COORD_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_rec_valid,
    input  logic [2*(COORD_BITS+2*qbs_pkg::num_bits(COORD_BITS)
                     +2*qbs_pkg::rem_bits(SAMPLE_STEPS))-1:0] i_rec,
    output logic                                 o_rec_take,
    output logic                                 empty,
    input  logic                                 pop,
    output logic signed [qbs_pkg::OUT_BITS-1:0]  o_point_x,
    output logic signed [qbs_pkg::OUT_BITS-1:0]  o_point_y,
    output logic [qbs_pkg::IDX_BITS-1:0]         o_sample_index,
    output logic                                 o_is_last
);

    localparam int W  = qbs_pkg::num_bits(COORD_BITS);
    localparam int DW = qbs_pkg::rem_bits(SAMPLE_STEPS);
    localparam int D  = SAMPLE_STEPS * SAMPLE_STEPS;
    localparam int IB = qbs_pkg::IDX_BITS;
    localparam int OB = qbs_pkg::OUT_BITS;
    localparam logic signed [W:0] V_MAX = (W+1)'(2 ** (OB - 1) - 1);
    localparam logic signed [W:0] V_MIN = (W+1)'(-(2 ** (OB - 1)));

    // record fields
    logic signed [COORD_BITS-1:0] p0x, p0y;
    logic [W-1:0]  q1x, q2x, q1y, q2y;
    logic [DW-1:0] r1x, r2x, r1y, r2y;

    // stepper state
    logic          r_active;
    logic [IB-1:0] r_k;
    logic [W-1:0]  r_qx, r_dqx, r_q2x, r_qy, r_dqy, r_q2y;
    logic [DW-1:0] r_rx, r_drx, r_r2x, r_ry, r_dry, r_r2y;

    // output register
    logic                 r_ov;
    logic signed [OB-1:0] r_px, r_py;
    logic [IB-1:0]        r_idx;
    logic                 r_last;

    logic               n_out_ready;
    logic               n_emit;
    logic               n_at_end;
    logic               n_load;
    logic [W+DW-1:0]    n_sx, n_dx, n_sy, n_dy;
    logic signed [OB-1:0] n_vx, n_vy;

    assign {p0x, q1x, r1x, q2x, r2x, p0y, q1y, r1y, q2y, r2y} = i_rec;

    // add two values kept as quotient and remainder against the divisor
    function automatic logic [W+DW-1:0] qr_add(
        input logic [W-1:0]  qa,
        input logic [DW-1:0] ra,
        input logic [W-1:0]  qb,
        input logic [DW-1:0] rb
    );
        logic [DW:0]   sum;
        logic          carry;
        logic [DW-1:0] rem;
        sum   = {1'b0, ra} + {1'b0, rb};
        carry = (sum >= (DW+1)'(D));
        rem   = carry ? DW'(sum - (DW+1)'(D)) : sum[DW-1:0];
        return {qa + qb + W'(carry), rem};
    endfunction

    // half-pixel offset and clamp to the result range
    function automatic logic signed [OB-1:0] to_point(input logic [W-1:0] q);
        logic signed [W:0] v;
        v = (W+1)'(signed'(q)) + (W+1)'(qbs_pkg::HALF_PIXEL);
        if (v > V_MAX) begin
            v = V_MAX;
        end else if (v < V_MIN) begin
            v = V_MIN;
        end
        return v[OB-1:0];
    endfunction

    // handshake between stepper and output register
    assign n_out_ready = !r_ov || pop;
    assign n_emit      = r_active && n_out_ready;
    assign n_at_end    = (r_k == IB'(SAMPLE_STEPS));
    assign n_load      = i_rec_valid && (!r_active || (n_emit && n_at_end));
    assign o_rec_take  = n_load;

    // next differences
    always_comb begin
        n_sx = qr_add(r_qx, r_rx, r_dqx, r_drx);
        n_dx = qr_add(r_dqx, r_drx, r_q2x, r_r2x);
        n_sy = qr_add(r_qy, r_ry, r_dqy, r_dry);
        n_dy = qr_add(r_dqy, r_dry, r_q2y, r_r2y);
        n_vx = to_point(r_qx);
        n_vy = to_point(r_qy);
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_k      <= '0;
            r_ov     <= 1'b0;
        end else begin
            if (n_load) begin
                r_active <= 1'b1;
                r_k      <= '0;
            end else if (n_emit) begin
                r_active <= !n_at_end;
                r_k      <= r_k + IB'(1);
            end
            if (n_emit) begin
                r_ov <= 1'b1;
            end else if (pop) begin
                r_ov <= 1'b0;
            end
        end
    end

    // accumulators: start at 256*p0 with remainder half the divisor
    always_ff @(posedge i_clk) begin
        if (n_load) begin
            r_qx  <= W'(p0x) <<< qbs_pkg::FRAC_BITS;
            r_rx  <= DW'(D / 2);
            r_dqx <= q1x;
            r_drx <= r1x;
            r_q2x <= q2x;
            r_r2x <= r2x;
            r_qy  <= W'(p0y) <<< qbs_pkg::FRAC_BITS;
            r_ry  <= DW'(D / 2);
            r_dqy <= q1y;
            r_dry <= r1y;
            r_q2y <= q2y;
            r_r2y <= r2y;
        end else if (n_emit) begin
            {r_qx, r_rx}   <= n_sx;
            {r_dqx, r_drx} <= n_dx;
            {r_qy, r_ry}   <= n_sy;
            {r_dqy, r_dry} <= n_dy;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (n_emit) begin
            r_px   <= n_vx;
            r_py   <= n_vy;
            r_idx  <= r_k;
            r_last <= n_at_end;
        end
    end

    assign empty          = !r_ov;
    assign o_point_x      = r_px;
    assign o_point_y      = r_py;
    assign o_sample_index = r_idx;
    assign o_is_last      = r_last;

endmodule

>>> rtl/core/quadratic_bezier_sampler.sv
// quadratic bezier sampler: SAMPLE_STEPS+1 points per curve, one per cycle
// path: a curve goes through the dividers, queue, stepper and output register
// throughput: one point per cycle while the output register is free, set by the
// stepper's loop; the front end takes a curve once the previous record is queued
// reset: synchronous active low; clears queue, stepper and output register
module quadratic_bezier_sampler #(
    parameter int SAMPLE_STEPS = qbs_pkg::SAMPLE_STEPS_DEF,
    parameter int COORD_BITS   = qbs_pkg::COORD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic signed [COORD_BITS-1:0]        i_start_x,
    input  logic signed [COORD_BITS-1:0]        i_start_y,
    input  logic signed [COORD_BITS-1:0]        i_ctrl_x,
    input  logic signed [COORD_BITS-1:0]        i_ctrl_y,
    input  logic signed [COORD_BITS-1:0]        i_end_x,
    input  logic signed [COORD_BITS-1:0]        i_end_y,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [qbs_pkg::OUT_BITS-1:0] o_point_x,
    output logic signed [qbs_pkg::OUT_BITS-1:0] o_point_y,
    output logic [qbs_pkg::IDX_BITS-1:0]        o_sample_index,
    output logic                                o_is_last
);

    localparam int W   = qbs_pkg::num_bits(COORD_BITS);
    localparam int DW  = qbs_pkg::rem_bits(SAMPLE_STEPS);
    localparam int RW  = 2 * (COORD_BITS + 2 * W + 2 * DW);

    logic          q_wr;
    logic          q_full;
    logic [RW-1:0] q_wdata;
    logic          q_rd;
    logic          q_empty;
    logic [RW-1:0] q_rdata;

    // front end: accept a curve and derive its differences
    qbs_front #(.SAMPLE_STEPS(SAMPLE_STEPS), .COORD_BITS(COORD_BITS)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_start_x(i_start_x),
        .i_start_y(i_start_y),
        .i_ctrl_x (i_ctrl_x),
        .i_ctrl_y (i_ctrl_y),
        .i_end_x  (i_end_x),
        .i_end_y  (i_end_y),
        .i_q_full (q_full),
        .o_q_wr   (q_wr),
        .o_q_data (q_wdata)
    );

    // decoupling queue
    qbs_fifo #(.WIDTH(RW)) u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_wr   (q_wr),
        .i_data (q_wdata),
        .o_full (q_full),
        .i_rd   (q_rd),
        .o_empty(q_empty),
        .o_data (q_rdata)
    );

    // back end: step along the curve
    qbs_back #(.SAMPLE_STEPS(SAMPLE_STEPS), .COORD_BITS(COORD_BITS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rec_valid   (!q_empty),
        .i_rec         (q_rdata),
        .o_rec_take    (q_rd),
        .empty         (empty),
        .pop           (pop),
        .o_point_x     (o_point_x),
        .o_point_y     (o_point_y),
        .o_sample_index(o_sample_index),
        .o_is_last     (o_is_last)
    );

endmodule

>>> tb/sv/tb_quadratic_bezier_sampler.sv
// self-checking testbench for the quadratic bezier sampler
`timescale 1ns / 1ps

module tb_quadratic_bezier_sampler;

    localparam int STEPS  = qbs_pkg::SAMPLE_STEPS_DEF;
    localparam int CB     = qbs_pkg::COORD_BITS_DEF;
    localparam int OB     = qbs_pkg::OUT_BITS;
    localparam int IB     = qbs_pkg::IDX_BITS;
    localparam int N_RANDOM    = 246;
    localparam int CALM_ITEMS  = 30;
    localparam int HOLD_AFTER  = 600;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = CB + 40;

    // one curve point as it leaves the block
    typedef struct {
        logic signed [OB-1:0] x;
        logic signed [OB-1:0] y;
        logic [IB-1:0]        idx;
        logic                 last;
    } curve_point_t;

    // one stimulus row; fixed rows are flat curves whose points are known by eye
    typedef struct packed {
        logic signed [CB-1:0] sx;
        logic signed [CB-1:0] sy;
        logic signed [CB-1:0] cx;
        logic signed [CB-1:0] cy;
        logic signed [CB-1:0] ex;
        logic signed [CB-1:0] ey;
        logic                 fixed;
        logic signed [OB-1:0] fx;
        logic signed [OB-1:0] fy;
    } curve_row_t;

    localparam int N_DIRECTED = 14;
    localparam curve_row_t DIRECTED [N_DIRECTED] = '{
        // flat curves at zero, at the extremes and at minus one / plus one
        '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 24'sd128, 24'sd128},
        '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
          1'b1, 24'sd8388480, 24'sd8388480},
        '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
          1'b1, -24'sd8388480, -24'sd8388480},
        '{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768,
          1'b1, 24'sd8388480, -24'sd8388480},
        '{-16'sd1, 16'sd1, -16'sd1, 16'sd1, -16'sd1, 16'sd1, 1'b1, -24'sd128, 24'sd384},
        // full swing control and end points at the extremes and at zero
        '{-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768,
          1'b0, 24'sd0, 24'sd0},
        '{16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768,
          1'b0, 24'sd0, 24'sd0},
        '{-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768,
          1'b0, 24'sd0, 24'sd0},
        '{16'sd0, 16'sd0, 16'sd32767, -16'sd32768, 16'sd0, 16'sd0, 1'b0, 24'sd0, 24'sd0},
        // straight lines and small values around zero for rounding
        '{16'sd0, 16'sd0, 16'sd50, 16'sd100, 16'sd100, 16'sd200, 1'b0, 24'sd0, 24'sd0},
        '{-16'sd1, -16'sd1, 16'sd0, 16'sd0, 16'sd1, 16'sd1, 1'b0, 24'sd0, 24'sd0},
        '{16'sd1, -16'sd1, -16'sd1, 16'sd1, 16'sd0, 16'sd0, 1'b0, 24'sd0, 24'sd0},
        // alternating bit patterns
        '{16'sd21845, -16'sd21846, -16'sd21846, 16'sd21845, 16'sd21845, -16'sd21846,
          1'b0, 24'sd0, 24'sd0},
        '{-16'sd21846, 16'sd21845, 16'sd21845, -16'sd21846, -16'sd21846, 16'sd21845,
          1'b0, 24'sd0, 24'sd0}
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 push;
    logic                 full;
    logic signed [CB-1:0] i_start_x;
    logic signed [CB-1:0] i_start_y;
    logic signed [CB-1:0] i_ctrl_x;
    logic signed [CB-1:0] i_ctrl_y;
    logic signed [CB-1:0] i_end_x;
    logic signed [CB-1:0] i_end_y;
    logic                 empty;
    logic                 pop;
    logic signed [OB-1:0] o_point_x;
    logic signed [OB-1:0] o_point_y;
    logic [IB-1:0]        o_sample_index;
    logic                 o_is_last;

    // side information travelling with the offered curve
    logic                 row_fixed;
    logic signed [OB-1:0] row_fx;
    logic signed [OB-1:0] row_fy;

    curve_point_t pending_points[$];
    int           mismatches;
    int           points_checked;
    bit           calm;

    quadratic_bezier_sampler i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_start_x      (i_start_x),
        .i_start_y      (i_start_y),
        .i_ctrl_x       (i_ctrl_x),
        .i_ctrl_y       (i_ctrl_y),
        .i_end_x        (i_end_x),
        .i_end_y        (i_end_y),
        .empty          (empty),
        .pop            (pop),
        .o_point_x      (o_point_x),
        .o_point_y      (o_point_y),
        .o_sample_index (o_sample_index),
        .o_is_last      (o_is_last)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    // one coordinate of the curve at step k, rounded and shifted by half a pixel
    function automatic logic signed [OB-1:0] bezier_coord(input longint p0, input longint p1,
                                                           input longint p2, input longint k);
        longint n2;
        longint j;
        longint weighted;
        longint scaled;
        longint v;
        n2       = longint'(STEPS) * STEPS;
        j        = STEPS - k;
        weighted = j * j * p0 + 2 * k * j * p1 + k * k * p2;
        scaled   = weighted * (longint'(1) << qbs_pkg::FRAC_BITS) + n2 / 2;
        v        = (scaled >= 0) ? scaled / n2 : -((-scaled + n2 - 1) / n2);
        v        = v + qbs_pkg::HALF_PIXEL;
        if (v > 64'sd8388607)
            v = 64'sd8388607;
        if (v < -64'sd8388608)
            v = -64'sd8388608;
        return v[OB-1:0];
    endfunction

    // queue every point of one accepted curve
    function automatic void expect_curve(input longint sx, input longint sy,
                                         input longint cx, input longint cy,
                                         input longint ex, input longint ey,
                                         input logic fixed, input logic signed [OB-1:0] fx,
                                         input logic signed [OB-1:0] fy);
        curve_point_t pt;
        for (int k = 0; k <= STEPS; k++) begin
            pt.x    = fixed ? fx : bezier_coord(sx, cx, ex, k);
            pt.y    = fixed ? fy : bezier_coord(sy, cy, ey, k);
            pt.idx  = k[IB-1:0];
            pt.last = (k == STEPS);
            pending_points.push_back(pt);
        end
    endfunction

    function automatic void check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // watch both handshakes on pre-edge values
    always @(posedge i_clk) begin : watch
        curve_point_t want;
        if (i_rst_n) begin
            if (push && !full)
                expect_curve(i_start_x, i_start_y, i_ctrl_x, i_ctrl_y, i_end_x, i_end_y,
                             row_fixed, row_fx, row_fy);
            if (pop && !empty) begin
                points_checked++;
                if (pending_points.size() == 0) begin
                    $error("unexpected point transaction: x %0d y %0d index %0d",
                           o_point_x, o_point_y, o_sample_index);
                    mismatches++;
                end else begin
                    want = pending_points.pop_front();
                    check_field("point_x", want.x, o_point_x);
                    check_field("point_y", want.y, o_point_y);
                    check_field("sample_index", want.idx, o_sample_index);
                    check_field("is_last", want.last, o_is_last);
                end
            end
        end
    end

    // one random coordinate: full range, near zero or an extreme
    function automatic logic signed [CB-1:0] pick_coord();
        int mode;
        mode = $urandom_range(0, 99);
        if (mode < 60)
            return CB'($urandom);
        if (mode < 80)
            return CB'(int'($urandom_range(0, 200)) - 100);
        case ($urandom_range(0, 3))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            default: return 16'shffff;
        endcase
    endfunction

    // offer one curve and wait for its transaction
    task automatic offer_curve(input curve_row_t row);
        push      <= 1'b1;
        i_start_x <= row.sx;
        i_start_y <= row.sy;
        i_ctrl_x  <= row.cx;
        i_ctrl_y  <= row.cy;
        i_end_x   <= row.ex;
        i_end_y   <= row.ey;
        row_fixed <= row.fixed;
        row_fx    <= row.fx;
        row_fy    <= row.fy;
        do @(posedge i_clk); while (full);
    endtask

    // sender idle burst with junk on the data ports
    task automatic maybe_idle(input int idle_pct);
        if (!calm && $urandom_range(0, 99) < idle_pct) begin
            push      <= 1'b0;
            i_start_x <= CB'($urandom);
            i_start_y <= CB'($urandom);
            i_ctrl_x  <= CB'($urandom);
            i_ctrl_y  <= CB'($urandom);
            i_end_x   <= CB'($urandom);
            i_end_y   <= CB'($urandom);
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // receiver: random stall bursts, one long hold-off, none at the end
    initial begin : receiver
        int idle_pct;
        int iter;
        bit held;
        pop      <= 1'b0;
        idle_pct = 0;
        iter     = 0;
        held     = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (iter % 100 == 0) begin
                case ($urandom_range(0, 2))
                    0:       idle_pct = 0;
                    1:       idle_pct = 20;
                    default: idle_pct = 50;
                endcase
            end
            iter++;
            if (!held && points_checked >= HOLD_AFTER) begin
                held = 1;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end else begin
                pop <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // sender: reset, directed table, random curves, drain
    initial begin : sender
        curve_row_t row;
        int idle_pct;
        mismatches     = 0;
        points_checked = 0;
        calm           = 0;
        idle_pct       = 20;
        i_rst_n   <= 1'b0;
        push      <= 1'b0;
        i_start_x <= '0;
        i_start_y <= '0;
        i_ctrl_x  <= '0;
        i_ctrl_y  <= '0;
        i_end_x   <= '0;
        i_end_y   <= '0;
        row_fixed <= 1'b0;
        row_fx    <= '0;
        row_fy    <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows
        for (int r = 0; r < N_DIRECTED; r++) begin
            offer_curve(DIRECTED[r]);
            maybe_idle(idle_pct);
        end

        // random curves
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 20 == 0) begin
                case ($urandom_range(0, 2))
                    0:       idle_pct = 0;
                    1:       idle_pct = 20;
                    default: idle_pct = 50;
                endcase
            end
            if (n >= N_RANDOM - CALM_ITEMS)
                calm = 1;
            row.sx    = pick_coord();
            row.sy    = pick_coord();
            row.cx    = pick_coord();
            row.cy    = pick_coord();
            row.ex    = pick_coord();
            row.ey    = pick_coord();
            row.fixed = 1'b0;
            row.fx    = '0;
            row.fy    = '0;
            offer_curve(row);
            maybe_idle(idle_pct);
        end
        push <= 1'b0;

        // drain and let any stray transaction show up
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/qbs_pkg.sv
rtl/core/qbs_div.sv
rtl/core/qbs_front.sv
rtl/core/qbs_fifo.sv
rtl/core/qbs_back.sv
rtl/core/quadratic_bezier_sampler.sv
tb/sv/tb_quadratic_bezier_sampler.sv
